FILE: rtl/text_window_console_macros.svh
// Assertion helpers for the console engine.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef TEXT_WINDOW_CONSOLE_MACROS_SVH
`define TEXT_WINDOW_CONSOLE_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define TWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TWC_ASSERT_NOW(lbl, ante, cons, msg)
`define TWC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/twc_pkg.sv
`timescale 1ns / 1ps

package twc_pkg;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_FG     = 3'd4,
    REG_BG     = 3'd5
  } reg_idx_e;

  // One screen cell, character in the low byte.
  typedef struct packed {
    logic [3:0] bg;
    logic [3:0] fg;
    logic [7:0] ch;
  } cell_t;

  function automatic cell_t make_cell(input logic [7:0] ch, input logic [3:0] fg,
                                      input logic [3:0] bg);
    cell_t c;
    c.ch = ch;
    c.fg = fg;
    c.bg = bg;
    return c;
  endfunction

endpackage

FILE: rtl/twc_screen_ram.sv
`timescale 1ns / 1ps

// Screen store: one write port, one read port, registered read data.
module twc_screen_ram #(
  parameter int Depth = 2000,
  parameter int AddrW = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  twc_pkg::cell_t    wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output twc_pkg::cell_t    rdata_o
);
  import twc_pkg::*;

  cell_t mem_q [Depth];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/text_window_console.sv
`timescale 1ns / 1ps

// Text-mode console engine over a SCREEN_COLS x SCREEN_ROWS cell store (character,
// foreground, background), with a clamped window and default colours set through
// the write port. Each request returns exactly one result: the read cell (zero
// for anything but a read) and the cursor column afterwards. All screen work goes
// through the store's one write port and one read port at one cell per cycle,
// under a small sequencer, and one request is handled at a time. Each request
// passes setup; a printable character or carriage return then goes through the
// put state, a read through the read request and (if on screen) read data
// states, the unused op straight on. A clear sweeps the clamped window; a newline
// scrolls the window rows up and then blanks the bottom row; a character that
// wraps past the right edge scrolls and keeps the bottom row (a one-row window
// has nothing to scroll: a newline only blanks it, a wrap does no sweep). After
// reset the store is swept to zero, one cell per cycle, before the first request
// is taken; register writes are taken then.
module text_window_console #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // character[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // cell_char[7:0], cell_fg[11:8], cell_bg[15:12],
                                      // cursor_col[22:16]
  // register write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_wdata_i
);
  import twc_pkg::*;

  `include "text_window_console_macros.svh"

  localparam int XW    = $clog2(SCREEN_COLS + 1);          // 0 .. SCREEN_COLS
  localparam int YW    = $clog2(SCREEN_ROWS + 1);          // 0 .. SCREEN_ROWS
  localparam int CXW   = ((XW > 7) ? XW : 7) + 1;          // clamp arithmetic, columns
  localparam int CYW   = ((YW > 5) ? YW : 5) + 1;          // clamp arithmetic, rows
  localparam int Cells = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(Cells);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_CLR,
    S_PUT,
    S_RD_REQ,
    S_RD_DATA,
    S_SWEEP,
    S_TAIL,
    S_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [6:0] cfg_left_q, cfg_width_q;
  logic [4:0] cfg_top_q, cfg_height_q;
  logic [3:0] cfg_fg_q, cfg_bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_left_q   <= 7'd0;
      cfg_top_q    <= 5'd0;
      cfg_width_q  <= 7'd80;
      cfg_height_q <= 5'd25;
      cfg_fg_q     <= 4'd7;
      cfg_bg_q     <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LEFT:   cfg_left_q   <= cfg_wdata_i;
        REG_TOP:    cfg_top_q    <= cfg_wdata_i[4:0];
        REG_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        REG_HEIGHT: cfg_height_q <= cfg_wdata_i[4:0];
        REG_FG:     cfg_fg_q     <= cfg_wdata_i[3:0];
        REG_BG:     cfg_bg_q     <= cfg_wdata_i[3:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Window clamp, sampled when a request is taken
  // ---------------------------------------------------------------------------
  logic [CXW-1:0] left_ext, cl_l, width_ext, room_x, cl_w;
  logic [CYW-1:0] top_ext, cl_t, height_ext, room_y, cl_h;

  always_comb begin
    left_ext   = CXW'(cfg_left_q);
    cl_l       = (left_ext > CXW'(SCREEN_COLS - 1)) ? CXW'(SCREEN_COLS - 1) : left_ext;
    width_ext  = (cfg_width_q == 7'd0) ? CXW'(1) : CXW'(cfg_width_q);
    room_x     = CXW'(SCREEN_COLS) - cl_l;
    cl_w       = (width_ext > room_x) ? room_x : width_ext;

    top_ext    = CYW'(cfg_top_q);
    cl_t       = (top_ext > CYW'(SCREEN_ROWS - 1)) ? CYW'(SCREEN_ROWS - 1) : top_ext;
    height_ext = (cfg_height_q == 5'd0) ? CYW'(1) : CYW'(cfg_height_q);
    room_y     = CYW'(SCREEN_ROWS) - cl_t;
    cl_h       = (height_ext > room_y) ? room_y : height_ext;
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e         state_q;
  op_e            op_q;
  logic [7:0]     ch_q;
  logic [4:0]     rrow_q;
  logic [6:0]     rcol_q;

  logic [XW-1:0]  win_l_q, win_w_q, right_q;
  logic [YW-1:0]  win_t_q, win_h_q, bottom_q;
  logic [AW-1:0]  base_t_q, base_b_q;     // row bases of top and bottom window rows

  logic [XW-1:0]  cursor_q;

  // sweep engine: walks a row range of the window, one cell per cycle
  logic [XW-1:0]  x_q;
  logic [YW-1:0]  y_q, y_end_q;
  logic [AW-1:0]  base_q;
  logic           copy_q;       // 1: move each cell up a row, 0: fill with fill_q
  cell_t          fill_q;
  logic           init_q;       // post-reset clearing pass
  logic           blank_pend_q; // blank bottom row once the scroll is done
  logic           wr_pend_q;    // copy write lagging its read, due the cycle after it
  logic [AW-1:0]  wr_addr_q;

  cell_t          cell_q;
  logic           m_valid_q;
  cell_t          out_cell_q;
  logic [6:0]     out_cursor_q;

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic [XW-1:0]  cur, cur_next, x_next;
  logic [YW-1:0]  bot;
  logic [AW-1:0]  sw_addr, rd_addr;
  logic           row_end, sweep_last, rd_ok;
  cell_t          blank_cell;
  logic [CXW-1:0] cursor_ext;

  always_comb begin
    // a cursor left outside the window snaps to its left edge before a put
    cur        = (cursor_q < win_l_q || cursor_q >= right_q) ? win_l_q : cursor_q;
    cur_next   = cur + XW'(1);
    bot        = win_t_q + win_h_q - YW'(1);
    sw_addr    = base_q + AW'(x_q);
    x_next     = x_q + XW'(1);
    row_end    = (x_next == right_q);
    sweep_last = row_end && (y_q == y_end_q);
    rd_ok      = (32'(rrow_q) < SCREEN_ROWS) && (32'(rcol_q) < SCREEN_COLS);
    rd_addr    = AW'(rrow_q * SCREEN_COLS) + AW'(rcol_q);
    blank_cell = make_cell(CH_SPACE, cfg_fg_q, cfg_bg_q);
    cursor_ext = CXW'(cursor_q);
  end

  // ---------------------------------------------------------------------------
  // Store port
  // ---------------------------------------------------------------------------
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  cell_t         ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sw_addr;
    ram_wdata = fill_q;
    ram_re    = 1'b0;
    ram_raddr = sw_addr;
    unique case (state_q)
      S_SWEEP: begin
        if (copy_q) begin
          ram_re = 1'b1;
          if (wr_pend_q) begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_q;
            ram_wdata = ram_rdata;
          end
        end else begin
          ram_we = 1'b1;
        end
      end
      S_TAIL: begin
        ram_we    = wr_pend_q;
        ram_waddr = wr_addr_q;
        ram_wdata = ram_rdata;
      end
      S_PUT: begin
        if (ch_q != CH_NEWLINE && ch_q != CH_RETURN) begin
          ram_we    = 1'b1;
          ram_waddr = base_b_q + AW'(cur);
          ram_wdata = make_cell(ch_q, cfg_fg_q, cfg_bg_q);
        end
      end
      S_RD_REQ: begin
        ram_re    = rd_ok;
        ram_raddr = rd_addr;
      end
      default: ;
    endcase
  end

  twc_screen_ram #(
    .Depth (Cells),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // come out of reset sweeping the whole screen to zero
      state_q      <= S_SWEEP;
      cursor_q     <= '0;
      m_valid_q    <= 1'b0;
      wr_pend_q    <= 1'b0;
      copy_q       <= 1'b0;
      init_q       <= 1'b1;
      blank_pend_q <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
      y_end_q      <= YW'(SCREEN_ROWS - 1);
      base_q       <= '0;
      win_l_q      <= '0;
      right_q      <= XW'(SCREEN_COLS);
      fill_q       <= '0;
    end else begin
      // a copy read this cycle is written back the next
      wr_pend_q <= (state_q == S_SWEEP) && copy_q;
      // done only moves on once the result register is free, so it always
      // leaves a result standing
      if (state_q == S_DONE) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= op_e'(s_axis_tuser);
            ch_q    <= s_axis_tdata[7:0];
            rrow_q  <= s_axis_tdata[12:8];
            rcol_q  <= s_axis_tdata[19:13];
            win_l_q <= cl_l[XW-1:0];
            win_w_q <= cl_w[XW-1:0];
            win_t_q <= cl_t[YW-1:0];
            win_h_q <= cl_h[YW-1:0];
            state_q <= S_SETUP;
          end
        end

        S_SETUP: begin
          right_q  <= win_l_q + win_w_q;
          bottom_q <= bot;
          base_t_q <= AW'(win_t_q * SCREEN_COLS);
          base_b_q <= AW'(bot * SCREEN_COLS);
          cell_q   <= '0;
          unique case (op_q)
            OP_PUT:   state_q <= S_PUT;
            OP_READ:  state_q <= S_RD_REQ;
            OP_CLEAR: state_q <= S_CLR;
            default:  state_q <= S_DONE;
          endcase
        end

        S_CLR: begin
          x_q      <= win_l_q;
          y_q      <= win_t_q;
          y_end_q  <= bottom_q;
          base_q   <= base_t_q;
          copy_q   <= 1'b0;
          fill_q   <= blank_cell;
          cursor_q <= win_l_q;
          state_q  <= S_SWEEP;
        end

        S_PUT: begin
          if (ch_q == CH_NEWLINE) begin
            cursor_q <= win_l_q;
            x_q      <= win_l_q;
            y_end_q  <= bottom_q;
            if (win_h_q == YW'(1)) begin
              // single-row window: nothing to scroll, just blank it
              y_q    <= bottom_q;
              base_q <= base_b_q;
              copy_q <= 1'b0;
              fill_q <= blank_cell;
            end else begin
              y_q          <= win_t_q + YW'(1);
              base_q       <= base_t_q + AW'(SCREEN_COLS);
              copy_q       <= 1'b1;
              blank_pend_q <= 1'b1;
            end
            state_q <= S_SWEEP;
          end else if (ch_q == CH_RETURN) begin
            cursor_q <= win_l_q;
            state_q  <= S_DONE;
          end else if (cur_next == right_q) begin
            // wrap: scroll, bottom row keeps its old text
            cursor_q <= win_l_q;
            if (win_h_q == YW'(1)) begin
              state_q <= S_DONE;
            end else begin
              x_q          <= win_l_q;
              y_q          <= win_t_q + YW'(1);
              y_end_q      <= bottom_q;
              base_q       <= base_t_q + AW'(SCREEN_COLS);
              copy_q       <= 1'b1;
              blank_pend_q <= 1'b0;
              state_q      <= S_SWEEP;
            end
          end else begin
            cursor_q <= cur_next;
            state_q  <= S_DONE;
          end
        end

        S_RD_REQ: begin
          state_q <= rd_ok ? S_RD_DATA : S_DONE;
        end

        S_RD_DATA: begin
          cell_q  <= ram_rdata;
          state_q <= S_DONE;
        end

        S_SWEEP: begin
          if (copy_q) begin
            wr_addr_q <= sw_addr - AW'(SCREEN_COLS);
          end
          if (row_end) begin
            x_q    <= win_l_q;
            y_q    <= y_q + YW'(1);
            base_q <= base_q + AW'(SCREEN_COLS);
          end else begin
            x_q <= x_next;
          end
          if (sweep_last) begin
            if (copy_q) begin
              state_q <= S_TAIL;
            end else if (init_q) begin
              init_q  <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_DONE;
            end
          end
        end

        S_TAIL: begin
          // last copy write goes out this cycle
          if (blank_pend_q) begin
            blank_pend_q <= 1'b0;
            x_q          <= win_l_q;
            y_q          <= bottom_q;
            y_end_q      <= bottom_q;
            base_q       <= base_b_q;
            copy_q       <= 1'b0;
            fill_q       <= blank_cell;
            state_q      <= S_SWEEP;
          end else begin
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            out_cell_q   <= cell_q;
            out_cursor_q <= cursor_ext[6:0];
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_cursor_q, out_cell_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TWC_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "still ready")
  `TWC_ASSERT_NEXT(a_valid_from_done, !m_valid_q && state_q != S_DONE, !m_valid_q, "early result")
  `TWC_ASSERT_NOW(a_cursor_on_screen, 1'b1, 32'(cursor_q) < SCREEN_COLS, "cursor off screen")
  `TWC_ASSERT_NOW(a_idle_no_copy_write, s_axis_tready, !wr_pend_q, "copy write pending")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

// Checks the text console engine against an in-bench copy of its screen.
// Each request goes through one sender task. At acceptance that task updates
// the shadow screen and cursor and queues the reply it should give.
// A separate process pops that queue for every reply taken and compares it
// field by field. The run has a few directed requests on the reset window,
// then clamped windows, then random traffic. The random traffic has four
// gap/stall mixes and fresh window settings between chunks.
module tb;
  import twc_pkg::*;

  localparam int SCREEN_COLS    = 80;
  localparam int SCREEN_ROWS    = 25;
  // must outlast a full-screen scroll plus blank and the reset sweep
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int CHUNK_REQUESTS = 25;

  // expected reply, laid out as on m_axis_tdata
  typedef struct packed {
    logic [6:0] cursor;
    logic [3:0] bg;
    logic [3:0] fg;
    logic [7:0] ch;
  } console_reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = OP_PUT;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = REG_LEFT;
  logic [6:0]  cfg_wdata_i   = '0;

  text_window_console #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // character[7:0], read_row[12:8], read_col[19:13]
    .s_axis_tuser (s_axis_tuser),   // op[1:0]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // cell_char[7:0], cell_fg[11:8], cell_bg[15:12],
                                    // cursor_col[22:16]
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow state of the engine
  // ---------------------------------------------------------------------------
  cell_t      screen_shadow [SCREEN_COLS*SCREEN_ROWS];
  int         cursor_shadow;
  logic [6:0] reg_left, reg_width;
  logic [4:0] reg_top, reg_height;
  logic [3:0] reg_fg, reg_bg;
  // clamped window, refreshed whenever the registers change
  int         win_left, win_top, win_cols, win_rows;

  console_reply_t replies_due [$];

  int send_idle_pct   = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct  = 0;   // chance per cycle that tready is low
  int mismatches      = 0;
  int requests_sent   = 0;
  int replies_checked = 0;
  int window_settings = 0;
  int quiet_cycles    = 0;

  // Left/top pinned to the last column/row; zero size means one; size cut at
  // the screen edge.
  function automatic void clamp_window();
    win_left = (reg_left > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : int'(reg_left);
    win_top  = (reg_top > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : int'(reg_top);
    win_cols = (reg_width == 0) ? 1 : int'(reg_width);
    win_rows = (reg_height == 0) ? 1 : int'(reg_height);
    if (win_cols > SCREEN_COLS - win_left) win_cols = SCREEN_COLS - win_left;
    if (win_rows > SCREEN_ROWS - win_top) win_rows = SCREEN_ROWS - win_top;
  endfunction

  function automatic cell_t tinted_cell(input logic [7:0] ch);
    cell_t c;
    c.ch = ch;
    c.fg = reg_fg;
    c.bg = reg_bg;
    return c;
  endfunction

  // window rows move up by one; the bottom row keeps its contents
  function automatic void scroll_window();
    for (int y = win_top; y + 1 < win_top + win_rows; y++)
      for (int x = win_left; x < win_left + win_cols; x++)
        screen_shadow[y*SCREEN_COLS + x] = screen_shadow[(y+1)*SCREEN_COLS + x];
  endfunction

  function automatic void blank_row(input int row);
    for (int x = win_left; x < win_left + win_cols; x++)
      screen_shadow[row*SCREEN_COLS + x] = tinted_cell(CH_SPACE);
  endfunction

  // Apply one request to the shadow and return the reply it must produce.
  function automatic console_reply_t apply_request(input op_e op, input logic [7:0] ch,
                                                   input logic [4:0] rr,
                                                   input logic [6:0] rc);
    console_reply_t reply;
    int bottom;
    reply  = '0;
    bottom = win_top + win_rows - 1;
    case (op)
      OP_PUT: begin
        // cursor left stranded by a window change snaps to the left edge
        if (cursor_shadow < win_left || cursor_shadow >= win_left + win_cols)
          cursor_shadow = win_left;
        if (ch == CH_NEWLINE) begin
          cursor_shadow = win_left;
          scroll_window();
          blank_row(bottom);
        end else if (ch == CH_RETURN) begin
          cursor_shadow = win_left;
        end else begin
          screen_shadow[bottom*SCREEN_COLS + cursor_shadow] = tinted_cell(ch);
          cursor_shadow++;
        end
        // running off the right edge scrolls without blanking
        if (cursor_shadow >= win_left + win_cols) begin
          scroll_window();
          cursor_shadow = win_left;
        end
      end
      OP_READ: begin
        if (int'(rr) < SCREEN_ROWS && int'(rc) < SCREEN_COLS)
          {reply.bg, reply.fg, reply.ch} = screen_shadow[int'(rr)*SCREEN_COLS + int'(rc)];
      end
      OP_CLEAR: begin
        for (int y = win_top; y < win_top + win_rows; y++) blank_row(y);
        cursor_shadow = win_left;
      end
      default: ;
    endcase
    reply.cursor = cursor_shadow[6:0];
    return reply;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Nothing moving on either stream for too long means a hang.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timed out: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Every reply taken is matched against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    console_reply_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply with no request outstanding: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        due = replies_due.pop_front();
        replies_checked++;
        if (m_axis_tdata[7:0] !== due.ch) begin
          $error("cell_char: expected %0d, got %0d", due.ch, m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[11:8] !== due.fg) begin
          $error("cell_fg: expected %0d, got %0d", due.fg, m_axis_tdata[11:8]);
          mismatches++;
        end
        if (m_axis_tdata[15:12] !== due.bg) begin
          $error("cell_bg: expected %0d, got %0d", due.bg, m_axis_tdata[15:12]);
          mismatches++;
        end
        if (m_axis_tdata[22:16] !== due.cursor) begin
          $error("cursor_col: expected %0d, got %0d", due.cursor, m_axis_tdata[22:16]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one request, with random hold-off first, and returns once taken.
  // tvalid stays high so back-to-back requests need no extra drive.
  task automatic send_request(input op_e op, input logic [7:0] ch,
                              input logic [4:0] rr, input logic [6:0] rc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, rc, rr, ch};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    replies_due.push_back(apply_request(op, ch, rr, rc));
    requests_sent++;
  endtask

  // Stop offering and wait until every reply is back.
  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // Writes all six registers in index order, only once the engine is idle.
  task automatic config_window(input int left, input int top, input int cols,
                               input int rows, input int fg, input int bg);
    int vals [6];
    vals = '{left, top, cols, rows, fg, bg};
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= reg_idx_e'(i);
      cfg_wdata_i <= vals[i][6:0];
      @(posedge clk_i);
      case (reg_idx_e'(i))
        REG_LEFT:   reg_left   = vals[i][6:0];
        REG_TOP:    reg_top    = vals[i][4:0];
        REG_WIDTH:  reg_width  = vals[i][6:0];
        REG_HEIGHT: reg_height = vals[i][4:0];
        REG_FG:     reg_fg     = vals[i][3:0];
        REG_BG:     reg_bg     = vals[i][3:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    clamp_window();
    window_settings++;
  endtask

  // Mostly character output, a good share of reads aimed at the window,
  // and the odd clear or unused op. Unused fields carry random noise.
  task automatic send_random_request();
    int pick;
    int sel;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    ch   = 8'($urandom_range(0, 255));
    rr   = 5'($urandom_range(0, 31));
    rc   = 7'($urandom_range(0, 127));
    if (pick < 55) begin
      if (sel < 12) ch = CH_NEWLINE;
      else if (sel < 20) ch = CH_RETURN;
      send_request(OP_PUT, ch, rr, rc);
    end else if (pick < 85) begin
      if (sel < 30) begin
        // bottom row, where the text lands
        rr = 5'(win_top + win_rows - 1);
        rc = 7'(win_left + $urandom_range(0, win_cols - 1));
      end else if (sel < 60) begin
        rr = 5'(win_top + $urandom_range(0, win_rows - 1));
        rc = 7'(win_left + $urandom_range(0, win_cols - 1));
      end else if (sel < 90) begin
        rr = 5'($urandom_range(0, SCREEN_ROWS - 1));
        rc = 7'($urandom_range(0, SCREEN_COLS - 1));
      end
      send_request(OP_READ, ch, rr, rc);
    end else if (pick < 92) begin
      send_request(OP_CLEAR, ch, rr, rc);
    end else begin
      send_request(OP_NONE, ch, rr, rc);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset window (full screen): swept store, edge reads, off-screen reads,
  // the unused op, extreme bytes, carriage return and one full-screen newline.
  task automatic test_reset_contents();
    send_request(OP_READ,  8'h00, 5'd0,  7'd0);
    send_request(OP_READ,  8'h00, 5'd24, 7'd79);
    send_request(OP_READ,  8'h00, 5'd25, 7'd0);
    send_request(OP_READ,  8'hff, 5'd31, 7'd127);
    send_request(OP_NONE,  8'hff, 5'd31, 7'd127);
    send_request(OP_PUT,   8'h48, 5'd0,  7'd0);
    send_request(OP_PUT,   8'h00, 5'd0,  7'd0);
    send_request(OP_PUT,   8'hff, 5'd0,  7'd0);
    send_request(OP_PUT,   CH_RETURN, 5'd0, 7'd0);
    send_request(OP_PUT,   8'h69, 5'd0,  7'd0);
    send_request(OP_READ,  8'h00, 5'd24, 7'd0);
    send_request(OP_PUT,   CH_NEWLINE, 5'd0, 7'd0);
    send_request(OP_READ,  8'h00, 5'd23, 7'd0);
    send_request(OP_READ,  8'h00, 5'd24, 7'd0);
  endtask

  // Out-of-range registers: a 1x1 window pinned to the bottom-right cell
  // (cursor starts outside it), then a 2-wide window cut at the right edge
  // where two characters force a wrap that keeps the bottom row.
  task automatic test_window_clamping();
    config_window(127, 31, 0, 0, 15, 15);
    send_request(OP_PUT,   8'h5a, 5'd0,  7'd0);
    send_request(OP_READ,  8'h00, 5'd24, 7'd79);
    send_request(OP_PUT,   CH_NEWLINE, 5'd0, 7'd0);
    send_request(OP_READ,  8'h00, 5'd24, 7'd79);
    config_window(78, 20, 127, 31, 0, 9);
    send_request(OP_CLEAR, 8'h00, 5'd0,  7'd0);
    send_request(OP_PUT,   8'h41, 5'd0,  7'd0);
    send_request(OP_PUT,   8'h42, 5'd0,  7'd0);
    send_request(OP_READ,  8'h00, 5'd23, 7'd78);
    send_request(OP_READ,  8'h00, 5'd24, 7'd79);
    send_request(OP_READ,  8'h00, 5'd19, 7'd78);
  endtask

  // Four gap/stall mixes, three window settings each. Windows are mostly
  // small so scrolls stay short; one in six spans up to the full screen.
  // Midway through the second chunk the sender drains before going on.
  task automatic test_random_traffic();
    int idle_mix [4];
    int stall_mix [4];
    bit wide;
    idle_mix  = '{0, 81, 0, 17};
    stall_mix = '{0, 0, 81, 17};
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_mix[phase];
      recv_stall_pct = stall_mix[phase];
      for (int chunk = 0; chunk < 3; chunk++) begin
        wide = ($urandom_range(0, 5) == 0);
        config_window(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 79),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(0, 24),
                      wide ? $urandom_range(0, 127) : $urandom_range(0, 12),
                      wide ? $urandom_range(0, 31) : $urandom_range(0, 6),
                      $urandom_range(0, 15), $urandom_range(0, 15));
        for (int n = 0; n < CHUNK_REQUESTS; n++) begin
          if (chunk == 1 && n == CHUNK_REQUESTS / 2) wait_for_replies();
          send_random_request();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (screen_shadow[i]) screen_shadow[i] = '0;
    cursor_shadow = 0;
    reg_left      = 7'd0;
    reg_top       = 5'd0;
    reg_width     = 7'd80;
    reg_height    = 5'd25;
    reg_fg        = 4'd7;
    reg_bg        = 4'd0;
    clamp_window();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_contents();
    test_window_clamping();
    test_random_traffic();

    wait_for_replies();
    repeat (50) @(posedge clk_i);

    $display("Checked %0d replies to %0d requests across %0d window settings,",
             replies_checked, requests_sent, window_settings);
    $display("with clamped windows, wraps, scrolls, clears and reads on and off screen.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/twc_pkg.sv
rtl/twc_screen_ram.sv
rtl/text_window_console.sv
tb/sv/tb.sv
